/* rtl/dotted_ipv4_text_parser_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dotted IPv4 text parser
// Clocked concurrent checks, reset-qualified or not, for the parser modules.
// ----------------------------------------------------------------------------
`ifndef DOTTED_IPV4_TEXT_PARSER_CORE_ASSERT_SVH
`define DOTTED_IPV4_TEXT_PARSER_CORE_ASSERT_SVH

// Check prop at every rising edge of clk outside reset.
`define DIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check prop at every rising edge of clk, reset included.
`define DIP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/dip_pkg.sv */
// ----------------------------------------------------------------------------
// Dotted IPv4 text parser package
// Token, state and queue types, constants and the character classifier.
// ----------------------------------------------------------------------------
package dip_pkg;

    localparam int TOK_Q_DEPTH = 4;
    localparam int TOK_Q_AW    = $clog2(TOK_Q_DEPTH);
    localparam int TOK_Q_CW    = $clog2(TOK_Q_DEPTH + 1);

    // Widest legal last part for two, three and four part forms
    localparam logic [31:0] LAST_LIM_2 = 32'h00ff_ffff;
    localparam logic [31:0] LAST_LIM_3 = 32'h0000_ffff;
    localparam logic [31:0] LAST_LIM_4 = 32'h0000_00ff;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_LO_X = 8'h78;
    localparam logic [7:0] CH_UP_X = 8'h58;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_FF   = 8'h0c;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_HT   = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0b;

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_HEXL,
        TK_DOT,
        TK_NUL,
        TK_WS,
        TK_XCH,
        TK_OTHER
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] val;
    } token_t;

    typedef struct packed {
        logic   valid;
        token_t tok;
    } tok_beat_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_OCT,
        RX_HEX
    } radix_t;

    function automatic token_t classify(input logic [7:0] c);
        token_t t;
        t.kind = TK_OTHER;
        t.val  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            t.kind = TK_DIGIT;
            t.val  = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            t.kind = TK_HEXL;
            t.val  = c[3:0] + 4'd9;
        end else if (c == CH_DOT) begin
            t.kind = TK_DOT;
        end else if (c == CH_NUL) begin
            t.kind = TK_NUL;
        end else if (c == CH_LO_X || c == CH_UP_X) begin
            t.kind = TK_XCH;
        end else if (c == CH_SP || c == CH_FF || c == CH_LF || c == CH_CR ||
                     c == CH_HT || c == CH_VT) begin
            t.kind = TK_WS;
        end
        return t;
    endfunction

endpackage

/* rtl/dip_front.sv */
// ----------------------------------------------------------------------------
// Dotted IPv4 parser front end
// Accept characters and register them as classified tokens.
// ----------------------------------------------------------------------------
module dip_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [7:0]          ch,
    output logic                full,
    input  logic                q_full,
    output dip_pkg::tok_beat_t  q_wr
);
    import dip_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    token_t tok_reg;
    logic   take;
    logic   drain;

    assign drain = valid_reg && !q_full;
    assign full  = valid_reg && q_full;
    assign take  = push && !full;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg <= classify(ch);
        end
    end

    assign q_wr.valid = drain;
    assign q_wr.tok   = tok_reg;

endmodule

/* rtl/dip_tok_queue.sv */
// ----------------------------------------------------------------------------
// Dotted IPv4 parser token queue
// Short show-ahead queue of tokens between front end and parser.
// ----------------------------------------------------------------------------
`include "dotted_ipv4_text_parser_core_assert.svh"

module dip_tok_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  dip_pkg::tok_beat_t  wr,
    output logic                q_full,
    output dip_pkg::tok_beat_t  rd,
    input  logic                rd_pop
);
    import dip_pkg::*;

    token_t                mem [TOK_Q_DEPTH];
    logic [TOK_Q_AW-1:0]   wr_ptr_reg;
    logic [TOK_Q_AW-1:0]   rd_ptr_reg;
    logic [TOK_Q_CW-1:0]   count_reg;
    logic [TOK_Q_CW-1:0]   count_next;

    assign q_full   = (count_reg == TOK_Q_CW'(TOK_Q_DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.tok   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr.valid && !rd_pop)
        begin
            count_next = count_reg + TOK_Q_CW'(1);
        end
        else if (!wr.valid && rd_pop)
        begin
            count_next = count_reg - TOK_Q_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + TOK_Q_AW'(1);
            end
            if (rd_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + TOK_Q_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            mem[wr_ptr_reg] <= wr.tok;
        end
    end

    `DIP_ASSERT(a_tq_no_overflow, (count_reg == TOK_Q_CW'(TOK_Q_DEPTH)) |-> !wr.valid, "token queue written while full")
    `DIP_ASSERT(a_tq_no_underflow, (count_reg == '0) |-> !rd_pop, "token queue popped while empty")

endmodule

/* rtl/dip_back.sv */
// ----------------------------------------------------------------------------
// Dotted IPv4 parser back end
// Run the part state machine on tokens and queue finished addresses.
// ----------------------------------------------------------------------------
`include "dotted_ipv4_text_parser_core_assert.svh"

module dip_back (
    input  logic                clk,
    input  logic                rst_n,
    input  dip_pkg::tok_beat_t  rd,
    output logic                rd_pop,
    output logic                empty,
    input  logic                pop,
    output logic [31:0]         address,
    output logic                ok
);
    import dip_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    radix_t      radix_reg;
    radix_t      radix_next;
    radix_t      eff_radix;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [1:0]  part_count_reg;
    logic [1:0]  part_count_next;
    logic [31:0] parts_reg [3];
    logic        part_wr;

    logic [31:0] acc_scaled;
    logic [31:0] acc_digit;
    logic [31:0] fin_addr;
    logic        fin_ok;
    logic        do_step;
    logic        is_nul;

    logic        emit;
    logic [31:0] emit_addr;
    logic        emit_ok;

    logic [31:0] rq_addr_reg [2];
    logic        rq_ok_reg [2];
    logic        rq_wr_ptr_reg;
    logic        rq_rd_ptr_reg;
    logic [1:0]  rq_count_reg;
    logic        rq_pop;

    assign is_nul = (rd.tok.kind == TK_NUL);
    // Stall only a string end while the result queue is full
    assign rd_pop = rd.valid && (!is_nul || rq_count_reg != 2'd2);

    // Right after a leading zero the part continues in octal
    assign eff_radix = (phase_reg == PH_ZERO) ? RX_OCT : radix_reg;

    always_comb
    begin
        case (eff_radix)
            RX_HEX:  acc_scaled = {acc_reg[27:0], 4'd0};
            RX_OCT:  acc_scaled = {acc_reg[28:0], 3'd0};
            default: acc_scaled = {acc_reg[28:0], 3'd0} + {acc_reg[30:0], 1'b0};
        endcase
        acc_digit = acc_scaled + {28'd0, rd.tok.val};
    end

    // Check the last part against its form and merge the stored parts
    always_comb
    begin
        case (part_count_reg)
            2'd0:
            begin
                fin_ok   = 1'b1;
                fin_addr = acc_reg;
            end
            2'd1:
            begin
                fin_ok   = (acc_reg <= LAST_LIM_2);
                fin_addr = acc_reg | {parts_reg[0][7:0], 24'd0};
            end
            2'd2:
            begin
                fin_ok   = (acc_reg <= LAST_LIM_3);
                fin_addr = acc_reg | {parts_reg[0][7:0], 24'd0}
                                   | {parts_reg[1][15:0], 16'd0};
            end
            default:
            begin
                fin_ok   = (acc_reg <= LAST_LIM_4);
                fin_addr = acc_reg | {parts_reg[0][7:0], 24'd0}
                                   | {parts_reg[1][15:0], 16'd0}
                                   | {parts_reg[2][23:0], 8'd0};
            end
        endcase
        if (!fin_ok)
        begin
            fin_addr = '0;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        radix_next      = radix_reg;
        acc_next        = acc_reg;
        part_count_next = part_count_reg;
        part_wr         = 1'b0;
        do_step         = 1'b0;
        emit            = 1'b0;
        emit_addr       = '0;
        emit_ok         = 1'b0;

        if (rd_pop)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (rd.tok.kind == TK_DIGIT)
                    begin
                        if (rd.tok.val == 4'd0)
                        begin
                            phase_next = PH_ZERO;
                            radix_next = RX_OCT;
                            acc_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_DIGITS;
                            radix_next = RX_DEC;
                            acc_next   = {28'd0, rd.tok.val};
                        end
                    end
                    else if (is_nul)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_ZERO:
                begin
                    phase_next = PH_DIGITS;
                    if (rd.tok.kind == TK_XCH)
                    begin
                        radix_next = RX_HEX;
                    end
                    else
                    begin
                        radix_next = RX_OCT;
                        do_step    = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    do_step = 1'b1;
                end
                PH_DONE:
                begin
                    if (is_nul)
                    begin
                        emit      = 1'b1;
                        emit_addr = fin_addr;
                        emit_ok   = fin_ok;
                    end
                end
                default:
                begin
                    if (is_nul)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
            endcase

            if (do_step)
            begin
                case (rd.tok.kind)
                    TK_DIGIT:
                    begin
                        acc_next = acc_digit;
                    end
                    TK_HEXL:
                    begin
                        if (eff_radix == RX_HEX)
                        begin
                            acc_next = acc_digit;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                        end
                    end
                    TK_DOT:
                    begin
                        if (part_count_reg == 2'd3)
                        begin
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            part_wr         = 1'b1;
                            part_count_next = part_count_reg + 2'd1;
                            phase_next      = PH_START;
                            radix_next      = RX_DEC;
                            acc_next        = '0;
                        end
                    end
                    TK_NUL:
                    begin
                        emit      = 1'b1;
                        emit_addr = fin_addr;
                        emit_ok   = fin_ok;
                    end
                    TK_WS:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_ERROR;
                    end
                endcase
            end

            // A finished string restarts the parser
            if (emit)
            begin
                phase_next      = PH_START;
                radix_next      = RX_DEC;
                acc_next        = '0;
                part_count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            radix_reg      <= RX_DEC;
            acc_reg        <= '0;
            part_count_reg <= 2'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            radix_reg      <= radix_next;
            acc_reg        <= acc_next;
            part_count_reg <= part_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (part_wr)
        begin
            parts_reg[part_count_reg] <= acc_reg;
        end
    end

    // Two-entry result queue
    assign empty   = (rq_count_reg == 2'd0);
    assign rq_pop  = pop && !empty;
    assign address = rq_addr_reg[rq_rd_ptr_reg];
    assign ok      = rq_ok_reg[rq_rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_ptr_reg <= 1'b0;
            rq_rd_ptr_reg <= 1'b0;
            rq_count_reg  <= 2'd0;
        end
        else
        begin
            if (emit)
            begin
                rq_wr_ptr_reg <= ~rq_wr_ptr_reg;
            end
            if (rq_pop)
            begin
                rq_rd_ptr_reg <= ~rq_rd_ptr_reg;
            end
            if (emit && !rq_pop)
            begin
                rq_count_reg <= rq_count_reg + 2'd1;
            end
            else if (!emit && rq_pop)
            begin
                rq_count_reg <= rq_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rq_addr_reg[rq_wr_ptr_reg] <= emit_addr;
            rq_ok_reg[rq_wr_ptr_reg]   <= emit_ok;
        end
    end

    `DIP_ASSERT(a_rq_no_overflow, (rq_count_reg == 2'd2) |-> !emit, "result queue written while full")
    `DIP_ASSERT(a_emit_restart, emit |=> (phase_reg == PH_START && part_count_reg == 2'd0 && acc_reg == '0), "parser not restarted after string end")
    `DIP_ASSERT(a_err_addr_zero, (emit && !emit_ok) |-> (emit_addr == '0), "rejected string carries nonzero address")
    `DIP_ASSERT(a_rq_count_range, rq_count_reg != 2'd3, "result queue count out of range")

endmodule

/* rtl/dotted_ipv4_text_parser_core.sv */
// ----------------------------------------------------------------------------
// Dotted IPv4 text parser core
// Parse an inet_aton style address string, one character per item.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload
//   -------   ----------------   ------------------------------------
//   in        push / full        ch[7:0], NUL ends the string
//   out       pop / empty        address[31:0], ok
//
// One character is accepted every cycle while full is low.
// An accepted character passes through the classify register and then
// the token queue before it reaches the parser.
// A result passes from the token queue through the parser into the
// result queue registers, where pop can take it.
// Reset clears all control state; the stored parts are not cleared.
// A full result queue stalls only a NUL; the token queue absorbs it and
// full rises once the queue and the classify register are both occupied.
// ----------------------------------------------------------------------------
module dotted_ipv4_text_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  ch,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] address,
    output logic        ok
);
    import dip_pkg::*;

    tok_beat_t q_wr;
    tok_beat_t q_rd;
    logic      q_full;
    logic      q_pop;

    // Classify each character and hold it for the token queue
    dip_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .ch     (ch),
        .full   (full),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    // Decouple the classifier from the parser
    dip_tok_queue u_tok_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .q_full (q_full),
        .rd     (q_rd),
        .rd_pop (q_pop)
    );

    // Advance the part state machine and queue finished addresses
    dip_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (q_rd),
        .rd_pop  (q_pop),
        .empty   (empty),
        .pop     (pop),
        .address (address),
        .ok      (ok)
    );

endmodule

/* tb/ipv4_parse_checker.sv */
// ----------------------------------------------------------------------------
// Dotted IPv4 parser checker
// Watch both queue channels, predict each address string's result and
// compare it field by field with what the parser core hands out.
// ----------------------------------------------------------------------------
module ipv4_parse_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  ch,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] address,
    input  logic        ok,
    output int          errors,
    output int          waiting,
    output int          results_checked,
    output int          results_good
);
    import dip_pkg::*;

    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    typedef struct packed {
        logic [31:0] address;
        logic        ok;
    } parse_result_t;

    parse_result_t addr_expected[$];

    // Parser state as predicted
    phase_t      phase;
    radix_t      radix;
    logic [31:0] acc;
    logic [1:0]  part_count;
    logic [31:0] parts[3];

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_DIGIT0 && c <= CH_DIGIT9;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SP || c == CH_FF || c == CH_LF || c == CH_CR ||
               c == CH_HT || c == CH_VT;
    endfunction

    task automatic restart_string();
        phase      = PH_START;
        radix      = RX_DEC;
        acc        = 32'd0;
        part_count = 2'd0;
    endtask

    task automatic emit_result(input logic [31:0] value, input logic good);
        parse_result_t r;
        r.address = value;
        r.ok      = good;
        addr_expected.push_back(r);
        restart_string();
    endtask

    // Check the last part against its width, then merge the stored parts.
    task automatic close_string();
        case (part_count)
            2'd0: emit_result(acc, 1'b1);
            2'd1:
                if (acc > LAST_LIM_2) emit_result(32'd0, 1'b0);
                else emit_result(acc | (parts[0] << 24), 1'b1);
            2'd2:
                if (acc > LAST_LIM_3) emit_result(32'd0, 1'b0);
                else emit_result(acc | (parts[0] << 24) | (parts[1] << 16), 1'b1);
            default:
                if (acc > LAST_LIM_4) emit_result(32'd0, 1'b0);
                else emit_result(acc | (parts[0] << 24) | (parts[1] << 16) |
                                 (parts[2] << 8), 1'b1);
        endcase
    endtask

    task automatic digit_char(input logic [7:0] c);
        logic [31:0] base;
        base = (radix == RX_HEX) ? 32'd16 : (radix == RX_OCT) ? 32'd8 : 32'd10;
        if (is_digit(c)) begin
            acc = acc * base + 32'(c - CH_DIGIT0);
        end else if (radix == RX_HEX && c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            acc = (acc << 4) | 32'(c - CH_LOWER_A + 8'd10);
        end else if (radix == RX_HEX && c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            acc = (acc << 4) | 32'(c - CH_UPPER_A + 8'd10);
        end else if (c == CH_DOT) begin
            if (part_count == 2'd3) begin
                phase = PH_ERROR;
            end else begin
                parts[part_count] = acc;
                part_count        = part_count + 2'd1;
                phase             = PH_START;
                radix             = RX_DEC;
                acc               = 32'd0;
            end
        end else if (c == CH_NUL) begin
            close_string();
        end else if (is_space(c)) begin
            phase = PH_DONE;
        end else begin
            phase = PH_ERROR;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        case (phase)
            PH_START:
                if (is_digit(c)) begin
                    if (c == CH_DIGIT0) begin
                        phase = PH_ZERO;
                        radix = RX_OCT;
                        acc   = 32'd0;
                    end else begin
                        phase = PH_DIGITS;
                        radix = RX_DEC;
                        acc   = 32'(c - CH_DIGIT0);
                    end
                end else if (c == CH_NUL) begin
                    emit_result(32'd0, 1'b0);
                end else begin
                    phase = PH_ERROR;
                end
            PH_ZERO: begin
                phase = PH_DIGITS;
                if (c == CH_LO_X || c == CH_UP_X) begin
                    radix = RX_HEX;
                end else begin
                    radix = RX_OCT;
                    digit_char(c);
                end
            end
            PH_DIGITS: digit_char(c);
            PH_DONE:
                if (c == CH_NUL) close_string();
            default:
                if (c == CH_NUL) emit_result(32'd0, 1'b0);
                else phase = PH_ERROR;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h, expected %h",
                 results_checked, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t want;
        if (!rst_n) begin
            restart_string();
            addr_expected.delete();
            waiting = 0;
        end else begin
            // Compare first: a result never comes from a NUL taken this edge.
            if (pop && !empty) begin
                if (addr_expected.size() == 0) begin
                    report_mismatch("with nothing expected", address, 32'd0);
                end else begin
                    want = addr_expected.pop_front();
                    if (address !== want.address)
                        report_mismatch("address", address, want.address);
                    if (ok !== want.ok)
                        report_mismatch("ok", 32'(ok), 32'(want.ok));
                    if (want.ok)
                        results_good++;
                end
                results_checked++;
            end
            if (push && !full)
                parse_char(ch);
            waiting = addr_expected.size();
        end
    end

endmodule

/* tb/dotted_ipv4_text_parser_core_test.sv */
// ----------------------------------------------------------------------------
// Dotted IPv4 text parser core testbench
// Feed address strings one character per item, with random idling on both
// channels, and let the checker compare every result with its prediction.
// ----------------------------------------------------------------------------
module dotted_ipv4_text_parser_core_test;
    import dip_pkg::*;

    // Stop the random part once this many characters have gone in
    localparam int RANDOM_ITEMS = 1500;
    // Idle chance per cycle, in percent, on each side
    localparam int IDLE_PCT     = 21;
    // Cycles to watch after the last result; covers the NUL-to-result path
    localparam int DRAIN_CYCLES = 16;
    // Hard stop; a correct run needs a small fraction of this
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] WS_SET [6] = '{CH_SP, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR};

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push  = 1'b0;
    logic [7:0]  ch    = 8'h00;
    logic        pop   = 1'b0;
    logic        full;
    logic        empty;
    logic [31:0] address;
    logic        ok;

    // High while neither side may idle
    logic        calm  = 1'b0;

    int          errors;
    int          waiting;
    int          results_checked;
    int          results_good;
    int          char_count   = 0;
    int          string_count = 0;
    int          cycle_count  = 0;

    // Characters of the string being built, NUL not included
    logic [7:0]  text[$];

    dotted_ipv4_text_parser_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .ch      (ch),
        .empty   (empty),
        .pop     (pop),
        .address (address),
        .ok      (ok)
    );

    ipv4_parse_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .ch              (ch),
        .empty           (empty),
        .pop             (pop),
        .address         (address),
        .ok              (ok),
        .errors          (errors),
        .waiting         (waiting),
        .results_checked (results_checked),
        .results_good    (results_good)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bail out if the run hangs anywhere.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, waiting);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: pop most cycles, drop pop at random outside calm stretches.
    always @(posedge clk)
    begin
        pop <= rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    // Map 0..21 onto 0-9, a-f, A-F.
    function automatic logic [7:0] hex_symbol(input int r);
        if (r < 10)
            return CH_DIGIT0 + 8'(r);
        else if (r < 16)
            return CH_LOWER_A + 8'(r - 10);
        else
            return CH_UPPER_A + 8'(r - 16);
    endfunction

    // Offer one character; idle first at random, then hold it until taken.
    // Idle cycles drive junk on ch so that a dropped push is really ignored.
    task automatic send_char(input logic [7:0] c);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            ch   <= 8'($urandom_range(255));
            @(posedge clk);
        end
        push <= 1'b1;
        ch   <= c;
        do @(posedge clk); while (full);
        char_count++;
    endtask

    // Send the built text and its terminating NUL.
    task automatic send_text();
        foreach (text[i])
            send_char(text[i]);
        send_char(CH_NUL);
        string_count++;
    endtask

    task automatic send_string(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_text();
    endtask

    // Hold push low until every expected result has been popped. Sample the
    // checker's count on the falling edge, where it has settled.
    task automatic wait_for_results();
        push <= 1'b0;
        @(negedge clk);
        while (waiting != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Append one part: plain decimal, octal, hex, or a decimal near a limit or at random.
    task automatic append_part();
        int          kind;
        int          len;
        logic [31:0] value;
        string       digits;
        kind = $urandom_range(3);
        // Mostly short parts; a few long enough to wrap the accumulator
        len  = ($urandom_range(7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
        case (kind)
            0: begin
                text.push_back(hex_symbol($urandom_range(1, 9)));
                repeat (len - 1) text.push_back(hex_symbol($urandom_range(9)));
            end
            1: begin
                // Leading zero; digits 8 and 9 are allowed in octal here
                text.push_back(CH_DIGIT0);
                repeat (len - 1) text.push_back(hex_symbol($urandom_range(9)));
            end
            2: begin
                // Zero hex digits gives the bare prefix
                text.push_back(CH_DIGIT0);
                text.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
                repeat ($urandom_range(len)) text.push_back(hex_symbol($urandom_range(21)));
            end
            default: begin
                case ($urandom_range(6))
                    0: value = 32'd255;
                    1: value = 32'd256;
                    2: value = 32'd65535;
                    3: value = 32'd65536;
                    4: value = 32'h00ff_ffff;
                    5: value = 32'h0100_0000;
                    default: value = $urandom;
                endcase
                digits = $sformatf("%0d", value);
                for (int i = 0; i < digits.len(); i++)
                    text.push_back(digits[i]);
            end
        endcase
    endtask

    // Build a mostly well-formed address: one to four parts, now and then a
    // fifth, a whitespace tail with trailing junk, or one corrupted character.
    task automatic build_address();
        int n_parts;
        text.delete();
        n_parts = ($urandom_range(9) == 0) ? 5 : $urandom_range(1, 4);
        for (int i = 0; i < n_parts; i++) begin
            if (i != 0)
                text.push_back(CH_DOT);
            append_part();
        end
        if ($urandom_range(5) == 0) begin
            text.push_back(WS_SET[$urandom_range(5)]);
            repeat ($urandom_range(3)) text.push_back(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(11) == 0)
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(1, 255));
    endtask

    // Build a short run of arbitrary non-NUL bytes, possibly empty.
    task automatic build_noise();
        text.delete();
        repeat ($urandom_range(8)) text.push_back(8'($urandom_range(1, 255)));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: empty, bad part start, junk after a part with the
        // top character code, a four part form mixing octal 9, upper and
        // lower hex, a bare hex prefix and a tab tail, a fourth dot, and a
        // last part too wide for its form.
        send_string("");
        send_string(".");
        send_string("1\377");
        send_string("09.0XaF.0x.7\tz");
        send_string("1.2.3.4.");
        send_string("1.2.3.256");

        // Drain fully before the random part starts.
        wait_for_results();

        while (char_count < RANDOM_ITEMS) begin
            // Open a stretch with no idling on either side
            calm <= (string_count >= 60 && string_count < 110);
            if ($urandom_range(99) < 80)
                build_address();
            else
                build_noise();
            send_text();
            if (string_count == 150)
                wait_for_results();
        end
        calm <= 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d strings with idling on both sides.",
                 char_count, string_count);
        $display("Checked %0d results, %0d of them well-formed addresses.",
                 results_checked, results_good);
        if (errors == 0 && waiting == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
